>>> rtl/bda_pkg.sv
// shared constants, state types and digit encoding for the binary to decimal ascii converter
package bda_pkg;

  localparam int IN_W           = 32;
  localparam int CHAR_W         = 6;
  localparam int OUT_W          = 8;
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_DIGITS = 10;

  localparam logic [3:0]        DEC_BASE   = 4'd10;
  localparam logic [3:0]        DIGIT_MAX  = 4'd9;
  localparam logic [3:0]        DABBLE_MIN = 4'd5;
  localparam logic [3:0]        DABBLE_ADD = 4'd3;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SHIFT,
    CV_HOLD
  } cv_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SKIP,
    EM_SEND
  } em_state_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [3:0] nib);
    logic [3:0] d;
    d = (nib >= DEC_BASE) ? DIGIT_MAX : nib;
    return CHAR_W'(d) + ASCII_ZERO;
  endfunction

endpackage

>>> rtl/binary_to_decimal_ascii_top.sv
// top level of the binary to decimal ascii converter
//
//  channel   dir  tdata                          tuser  tlast
//  s_axis    in   [31:0] value                   -      -
//  m_axis    out  [5:0] digit_char, [7:6] zero   -      last
//
// conversion: the idle state takes a value, the shift state takes one input bit per shift
// and the hold state hands the bcd over; s_axis takes no new value until the hand-over is done.
// the emitter then drops leading zeros before the first digit, and each digit leaves as
// one beat while the next value is converted.
// rst is synchronous and clears both control machines; no state lasts between values.
// a stall on m_axis holds the current digit and, once conversion ends, s_axis tready.
module binary_to_decimal_ascii_top #(
  parameter int VALUE_BITS = bda_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS = bda_pkg::DEF_MAX_DIGITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bda_pkg::IN_W-1:0]   s_axis_tdata,   // [31:0] value
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bda_pkg::OUT_W-1:0]  m_axis_tdata,   // [5:0] digit_char, [7:6] zero
  output logic                       m_axis_tlast
);
  import bda_pkg::*;

  logic                    bcd_valid;
  logic                    bcd_ready;
  logic [4*MAX_DIGITS-1:0] bcd;
  logic [CHAR_W-1:0]       digit_char;

  bda_conv #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_value  (s_axis_tdata),
    .out_valid (bcd_valid),
    .out_ready (bcd_ready),
    .out_bcd   (bcd)
  );

  bda_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bcd_valid),
    .in_ready  (bcd_ready),
    .in_bcd    (bcd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (digit_char),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_W - CHAR_W){1'b0}}, digit_char};

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[5:0] >= ASCII_ZERO && m_axis_tdata[5:0] <= ASCII_NINE))
    else $error("digit character out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken during conversion");

  a_digits_follow: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("digit run broken before last");

endmodule

>>> rtl/bda_conv.sv
// bit-serial shift-and-add-3 converter from binary to packed bcd
module bda_conv #(
  parameter int VALUE_BITS = bda_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS = bda_pkg::DEF_MAX_DIGITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bda_pkg::IN_W-1:0]  in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [4*MAX_DIGITS-1:0]   out_bcd
);
  import bda_pkg::*;

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(VALUE_BITS);

  cv_state_t             state;
  cv_state_t             state_next;
  logic [VALUE_BITS-1:0] bin;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      cnt;
  logic                  load;

  // add three to every digit of five or more before the shift
  always_comb begin
    logic [3:0] nib;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      nib = bcd[4*d +: 4];
      bcd_adj[4*d +: 4] = (nib >= DABBLE_MIN) ? nib + DABBLE_ADD : nib;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    load       = 1'b0;
    case (state)
      CV_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load       = 1'b1;
          state_next = CV_SHIFT;
        end
      end
      CV_SHIFT: begin
        if (cnt == '0) begin
          state_next = CV_HOLD;
        end
      end
      CV_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = CV_IDLE;
        end
      end
      default: begin
        state_next = CV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin <= VALUE_BITS'(in_value);
      bcd <= '0;
      cnt <= CNT_W'(VALUE_BITS - 1);
    end else if (state == CV_SHIFT) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_BITS-1]};
      bin <= bin << 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign out_bcd = bcd;

endmodule

>>> rtl/bda_emit.sv
// digit emitter: drops leading zeros and sends one ascii digit per beat
module bda_emit #(
  parameter int MAX_DIGITS = bda_pkg::DEF_MAX_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [4*MAX_DIGITS-1:0]     in_bcd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bda_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_last
);
  import bda_pkg::*;

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int IDX_W = $clog2(MAX_DIGITS);

  em_state_t        state;
  em_state_t        state_next;
  logic [BCD_W-1:0] bcd;
  logic [IDX_W-1:0] idx;
  logic [3:0]       top_nib;
  logic             load;
  logic             shift;

  assign top_nib = bcd[BCD_W-1 -: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    load       = 1'b0;
    shift      = 1'b0;
    case (state)
      EM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load       = 1'b1;
          state_next = EM_SKIP;
        end
      end
      EM_SKIP: begin
        if (top_nib == 4'd0 && idx != '0) begin
          shift = 1'b1;
        end else begin
          state_next = EM_SEND;
        end
      end
      EM_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (idx == '0) begin
            state_next = EM_IDLE;
          end else begin
            shift = 1'b1;
          end
        end
      end
      default: begin
        state_next = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd <= in_bcd;
      idx <= IDX_W'(MAX_DIGITS - 1);
    end else if (shift) begin
      bcd <= bcd << 4;
      idx <= idx - 1'b1;
    end
  end

  assign out_char = digit_to_char(top_nib);
  assign out_last = (idx == '0);

endmodule

>>> tb/sv/tb_binary_to_decimal_ascii_top.sv
// testbench for the binary to decimal ascii converter: streams values, checks every digit beat
module tb_binary_to_decimal_ascii_top;
  import bda_pkg::*;

  localparam int VALUE_BITS  = DEF_VALUE_BITS;
  localparam int MAX_DIGITS  = DEF_MAX_DIGITS;
  localparam int IDLE_PCT    = 28;
  localparam int RANDOM_ITEMS = 360;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * (VALUE_BITS + 2 * MAX_DIGITS + 4);

  class digit_scoreboard;
    typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
    } digit_beat_t;

    digit_beat_t pending_digits[$];
    int          error_count = 0;

    // double dabble, most significant bit first, digits out from the top non-zero one
    function void note_value(logic [IN_W-1:0] value);
      logic [3:0]  bcd [MAX_DIGITS];
      logic [4:0]  shifted;
      logic [3:0]  digit;
      logic        carry;
      int          top;
      digit_beat_t beat;
      foreach (bcd[d]) bcd[d] = 4'd0;
      for (int b = VALUE_BITS - 1; b >= 0; b--) begin
        carry = value[b];
        for (int d = 0; d < MAX_DIGITS; d++) begin
          if (bcd[d] >= DABBLE_MIN) bcd[d] = bcd[d] + DABBLE_ADD;
        end
        for (int d = 0; d < MAX_DIGITS; d++) begin
          shifted = {bcd[d], carry};
          carry   = shifted[4];
          bcd[d]  = shifted[3:0];
        end
      end
      top = 0;
      for (int d = MAX_DIGITS - 1; d > 0; d--) begin
        if (bcd[d] != 4'd0 && top == 0) top = d;
      end
      for (int d = top; d >= 0; d--) begin
        digit = (bcd[d] >= DEC_BASE) ? DIGIT_MAX : bcd[d];
        beat.digit_char = CHAR_W'(digit) + ASCII_ZERO;
        beat.last       = (d == 0);
        pending_digits.push_back(beat);
      end
    endfunction

    function void check_digit(logic [OUT_W-1:0] tdata, logic tlast);
      digit_beat_t want;
      if (pending_digits.size() == 0) begin
        $error("unexpected digit beat: digit_char %0d last %0b", tdata[CHAR_W-1:0], tlast);
        error_count++;
        return;
      end
      want = pending_digits.pop_front();
      if (tdata[CHAR_W-1:0] !== want.digit_char) begin
        $error("digit_char: expected %0d, got %0d", want.digit_char, tdata[CHAR_W-1:0]);
        error_count++;
      end
      if (tlast !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, tlast);
        error_count++;
      end
      if (tdata[OUT_W-1:CHAR_W] !== '0) begin
        $error("pad: expected 0, got %0d", tdata[OUT_W-1:CHAR_W]);
        error_count++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;
  bit                calm = 1'b0;

  digit_scoreboard digits = new();

  binary_to_decimal_ascii_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) digits.check_digit(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_binary_to_decimal_ascii_top: done, errors");
    $finish;
  end

  task automatic send_value(input logic [IN_W-1:0] value);
    int idle;
    idle = 0;
    while (!calm && $urandom_range(99) < IDLE_PCT) idle++;
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (idle) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    digits.note_value(value);
  endtask

  task automatic wait_for_digits();
    while (digits.pending_digits.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] random_value();
    int          width;
    logic [IN_W-1:0] mask;
    case ($urandom_range(9))
      0:       return '1;
      1:       return '0;
      default: begin
        width = $urandom_range(1, IN_W);
        mask  = (width == IN_W) ? '1 : ((IN_W'(1) << width) - 1);
        return $urandom & mask;
      end
    endcase
  endfunction

  logic [IN_W-1:0] directed_values[$] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd10000, 32'd12345,
    32'd65535, 32'd65536, 32'd999999999, 32'd1000000000, 32'd1000000001,
    32'd2147483647, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd4294967294, 32'd4294967295, 32'd7, 32'd90807060
  };

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_values[i]) send_value(directed_values[i]);
    // hold off until the directed digits are all out
    s_axis_tvalid <= 1'b0;
    wait_for_digits();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 140 && n < 210);
      send_value(random_value());
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    wait_for_digits();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digits.error_count == 0) begin
      $display("tb_binary_to_decimal_ascii_top: done, clean");
    end else begin
      $display("tb_binary_to_decimal_ascii_top: done, errors");
    end
    $finish;
  end

endmodule
